// ===== hw/rtl/pcbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcbs_pkg: shared types and helpers for the per-class box suppression core
// Box, corner and cell record types, register indexes, sequencer states and
// the corner arithmetic shared by the candidate front end and the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pcbs_pkg;

	localparam int MAX_BOXES_DEF = 64;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 16;
	localparam logic [15:0] OVERLAP_THR_RESET = 16'd29491;
	// Length of ST_CALC: from a candidate being captured to the cell hits being valid.
	localparam int CALC_CYCLES   = 6;
	localparam int CALC_CNT_W    = 3;
	localparam logic [17:0] HALF_ONE = 18'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCORE_THR   = 1'b0,
		REG_OVERLAP_THR = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_LOAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [15:0] box_width;
		logic [15:0] box_height;
		logic [7:0]  class_id;
		logic [15:0] score;
		logic        final_box;
	} in_item_t;

	typedef struct packed {
		logic [15:0] kept_x;
		logic [15:0] kept_y;
		logic [15:0] kept_width;
		logic [15:0] kept_height;
		logic [7:0]  kept_class;
		logic [15:0] kept_score;
		logic        valid_res;
		logic        overflowed;
		logic        last_result;
	} out_item_t;

	// Clipped corners in half-units; a low corner is not clipped above.
	typedef struct packed {
		logic [16:0] lo_x;
		logic [15:0] hi_x;
		logic [16:0] lo_y;
		logic [15:0] hi_y;
	} corners_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [15:0] h;
		logic [7:0]  cls;
		logic [15:0] score;
		corners_t    cor;
		logic [30:0] area;
		logic        sup;
		logic        valid;
	} entry_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic flush;
	} cell_ctrl_t;

	function automatic logic [15:0] span(logic [16:0] lo, logic [15:0] hi);
		logic [16:0] hi_e;
		hi_e = {1'b0, hi};
		if (hi_e > lo) begin
			span = 16'(hi_e - lo);
		end else begin
			span = 16'd0;
		end
	endfunction

	function automatic corners_t box_corners(logic [15:0] x, logic [15:0] y,
			logic [15:0] w, logic [15:0] h);
		logic [17:0] cx2, cy2, hx, hy;
		corners_t c;
		cx2 = {1'b0, x, 1'b0};
		cy2 = {1'b0, y, 1'b0};
		hx  = cx2 + {2'b00, w};
		hy  = cy2 + {2'b00, h};
		c.lo_x = (cx2 > {2'b00, w}) ? 17'(cx2 - {2'b00, w}) : 17'd0;
		c.lo_y = (cy2 > {2'b00, h}) ? 17'(cy2 - {2'b00, h}) : 17'd0;
		c.hi_x = (hx > HALF_ONE) ? HALF_ONE[15:0] : hx[15:0];
		c.hi_y = (hy > HALF_ONE) ? HALF_ONE[15:0] : hy[15:0];
		box_corners = c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pcbs_in_if.sv =====
// ----------------------------------------------------------------------------
// pcbs_in_if: input box channel
// Valid/ready channel carrying one detection box per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcbs_in_if
	import pcbs_pkg::*;
();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pcbs_out_if.sv =====
// ----------------------------------------------------------------------------
// pcbs_out_if: result channel
// Valid/ready channel carrying one kept box (or the empty marker) per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcbs_out_if
	import pcbs_pkg::*;
();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pcbs_cell.sv =====
// ----------------------------------------------------------------------------
// pcbs_cell: one storage cell of the box chain
// Holds one stored box, tests it against the current candidate through a
// five-stage overlap pipeline, and hands its contents to the cell below on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbs_cell
	import pcbs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cell_ctrl_t  ctrl,
	input  wire logic        prev_valid,
	input  wire entry_t      cand,
	input  wire entry_t      next_entry,
	input  wire logic [15:0] overlap_thr,
	output entry_t           entry,
	output logic             hit
);

	entry_t      data_q;
	logic        valid_q;
	logic        sup_q;
	logic        do_load;

	logic [15:0] ix_s1, iy_s1;
	logic        match_s1;
	logic [31:0] inter_s2;
	logic        match_s2;
	logic [31:0] uni_s3;
	logic [31:0] inter_s3;
	logic        match_s3;
	logic [47:0] prod_s4;
	logic [31:0] inter_s4;
	logic        nz_s4;
	logic        match_s4;
	logic        hit_s5;

	assign do_load = ctrl.load && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sup_q   <= 1'b0;
		end else if (ctrl.flush) begin
			valid_q <= 1'b0;
			sup_q   <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_entry.valid;
			sup_q   <= next_entry.sup;
		end else if (do_load) begin
			valid_q <= 1'b1;
			sup_q   <= cand.sup;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= next_entry;
		end else if (do_load) begin
			data_q <= cand;
		end
	end

	always_comb begin
		entry       = data_q;
		entry.valid = valid_q;
		entry.sup   = sup_q;
	end

	// Overlap test against the candidate; inputs hold steady while it runs.
	always_ff @(posedge clk) begin
		ix_s1    <= span((data_q.cor.lo_x > cand.cor.lo_x) ? data_q.cor.lo_x : cand.cor.lo_x,
			(data_q.cor.hi_x < cand.cor.hi_x) ? data_q.cor.hi_x : cand.cor.hi_x);
		iy_s1    <= span((data_q.cor.lo_y > cand.cor.lo_y) ? data_q.cor.lo_y : cand.cor.lo_y,
			(data_q.cor.hi_y < cand.cor.hi_y) ? data_q.cor.hi_y : cand.cor.hi_y);
		match_s1 <= valid_q && !sup_q && (data_q.cls == cand.cls);

		inter_s2 <= 32'(ix_s1) * 32'(iy_s1);
		match_s2 <= match_s1;

		uni_s3   <= 32'(data_q.area) + 32'(cand.area) - inter_s2;
		inter_s3 <= inter_s2;
		match_s3 <= match_s2;

		prod_s4  <= 48'(overlap_thr) * 48'(uni_s3);
		inter_s4 <= inter_s3;
		nz_s4    <= (uni_s3 != 32'd0);
		match_s4 <= match_s3;

		hit_s5   <= match_s4 && nz_s4 && ({inter_s4, 16'd0} >= prod_s4);
	end

	assign hit = hit_s5;

endmodule

`default_nettype wire

// ===== hw/rtl/per_class_box_suppression_core.sv =====
// ----------------------------------------------------------------------------
// per_class_box_suppression_core: per-class greedy box suppression
// Arrival-order IoU suppression over a chain of box cells, with end-of-image
// readout of the kept boxes.
// ----------------------------------------------------------------------------
// Each input box is captured, then held in ST_CALC while the candidate front end
// and the overlap pipeline that every cell runs in parallel against its stored box
// work, and then in ST_LOAD it is loaded into the first free cell if its score
// reaches the score threshold and the chain has room; only then is the block ready
// again. A box marked final_box then starts readout: the chain shifts towards cell 0
// one place per cycle unless a kept box at cell 0 is waiting, since a kept box leaves
// only when the result register is free. New boxes are taken again once the chain has drained.
`default_nettype none

module per_class_box_suppression_core
	import pcbs_pkg::*;
#(
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	pcbs_in_if.sink                    in_ch,
	pcbs_out_if.source                 out_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	state_t                state_q, state_d;
	logic [CALC_CNT_W-1:0] cnt_q;
	logic [15:0]           score_thr_q, overlap_thr_q;
	in_item_t              cand_q;
	corners_t              cc_d;
	corners_t              cc_s1;
	logic [15:0]           sx_s1, sy_s1;
	logic [30:0]           area_s2;
	entry_t                cand_entry;
	logic                  overflow_q, emitted_q;
	logic                  set_overflow, set_emitted;
	cell_ctrl_t            ctrl;
	logic                  out_load, out_free, any_hit, any_live, live_rest;
	out_item_t             out_d, out_q;
	logic                  out_valid_q;

	entry_t                cells   [MAX_BOXES];
	logic [MAX_BOXES-1:0]  hits, valids, lives;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_thr_q   <= '0;
			overlap_thr_q <= OVERLAP_THR_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SCORE_THR:   score_thr_q   <= cfg_data;
				REG_OVERLAP_THR: overlap_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);

	always_comb begin
		cc_d = box_corners(cand_q.center_x, cand_q.center_y,
			cand_q.box_width, cand_q.box_height);
	end

	// Candidate front end: corners, spans and area of the new box.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cand_q <= in_ch.data;
		end
		cc_s1   <= cc_d;
		sx_s1   <= span(cc_d.lo_x, cc_d.hi_x);
		sy_s1   <= span(cc_d.lo_y, cc_d.hi_y);
		area_s2 <= 31'(32'(sx_s1) * 32'(sy_s1));
	end

	always_comb begin
		cand_entry.x     = cand_q.center_x;
		cand_entry.y     = cand_q.center_y;
		cand_entry.w     = cand_q.box_width;
		cand_entry.h     = cand_q.box_height;
		cand_entry.cls   = cand_q.class_id;
		cand_entry.score = cand_q.score;
		cand_entry.cor   = cc_s1;
		cand_entry.area  = area_s2;
		cand_entry.sup   = any_hit;
		cand_entry.valid = 1'b1;
	end

	for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
		entry_t next_e;
		logic   prev_v;
		if (i == MAX_BOXES - 1) begin : g_tail
			always_comb begin
				next_e       = cells[i];
				next_e.valid = 1'b0;
				next_e.sup   = 1'b0;
			end
		end else begin : g_body
			assign next_e = cells[i+1];
		end
		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_link
			assign prev_v = cells[i-1].valid;
		end

		pcbs_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.prev_valid  (prev_v),
			.cand        (cand_entry),
			.next_entry  (next_e),
			.overlap_thr (overlap_thr_q),
			.entry       (cells[i]),
			.hit         (hits[i])
		);

		assign valids[i] = cells[i].valid;
		assign lives[i]  = cells[i].valid && !cells[i].sup;
	end

	assign any_hit   = |hits;
	assign any_live  = |lives;
	assign live_rest = |lives[MAX_BOXES-1:1];
	assign out_free  = !out_valid_q || out_ch.ready;

	always_comb begin
		state_d      = state_q;
		ctrl         = '0;
		out_load     = 1'b0;
		out_d        = '0;
		set_overflow = 1'b0;
		set_emitted  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (cnt_q == CALC_CNT_W'(CALC_CYCLES - 1)) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (cand_q.score >= score_thr_q) begin
					if (valids[MAX_BOXES-1]) begin
						set_overflow = 1'b1;
					end else begin
						ctrl.load = 1'b1;
					end
				end
				state_d = cand_q.final_box ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (!any_live) begin
					if (emitted_q) begin
						ctrl.flush = 1'b1;
						state_d    = ST_IDLE;
					end else if (out_free) begin
						// Nothing survived: a single empty result closes the run.
						out_load          = 1'b1;
						out_d.overflowed  = overflow_q;
						out_d.last_result = 1'b1;
						ctrl.flush        = 1'b1;
						state_d           = ST_IDLE;
					end
				end else if (cells[0].sup) begin
					ctrl.shift = 1'b1;
				end else if (out_free) begin
					out_load          = 1'b1;
					out_d.kept_x      = cells[0].x;
					out_d.kept_y      = cells[0].y;
					out_d.kept_width  = cells[0].w;
					out_d.kept_height = cells[0].h;
					out_d.kept_class  = cells[0].cls;
					out_d.kept_score  = cells[0].score;
					out_d.valid_res   = 1'b1;
					out_d.overflowed  = overflow_q;
					out_d.last_result = !live_rest;
					ctrl.shift        = 1'b1;
					set_emitted       = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			overflow_q <= 1'b0;
			emitted_q  <= 1'b0;
		end else begin
			cnt_q <= (state_q == ST_CALC) ? cnt_q + CALC_CNT_W'(1) : '0;
			if (ctrl.flush) begin
				overflow_q <= 1'b0;
			end else if (set_overflow) begin
				overflow_q <= 1'b1;
			end
			if (state_q != ST_EMIT) begin
				emitted_q <= 1'b0;
			end else if (set_emitted) begin
				emitted_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// The occupied cells always form an unbroken run starting at cell 0.
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(valids & (valids + MAX_BOXES'(1))) == '0)
		else $error("occupied cells are not contiguous");

	a_no_load_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |-> !valids[MAX_BOXES-1])
		else $error("load requested into a full chain");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(overflow_q) |-> $past(valids[MAX_BOXES-1]))
		else $error("overflow flagged while the chain had room");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && state_d == ST_IDLE) |=> (valids == '0 && !overflow_q))
		else $error("chain not cleared at the end of a run");

endmodule

`default_nettype wire
